/* src/cbs_pkg.sv */
package cbs_pkg;

	// table geometry
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;                   // point_count register
	localparam int COORD_W    = 32;                  // signed Q16.16
	localparam int U_W        = 17;                  // Q0.16, 65536 = 1.0
	localparam int SEG_W      = 7;                   // segment index / virtual point
	localparam int W_W        = 31;                  // unsigned Q0.30 weight
	localparam int NUM_W      = 52;                  // basis numerators at 6*S^3
	localparam int ACC_W      = 66;                  // lane accumulator

	localparam logic [U_W-1:0]   ONE_Q16  = 17'h10000;
	localparam logic [CNT_W-1:0] MIN_CNT  = 7'd4;
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_POINTS);
	localparam logic [31:0]      RECIP3   = 32'hAAAA_AAAB;   // ceil(2^33 / 3)
	localparam logic [1:0]       LAST_TAP = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMPED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 1'b1;

	// item kinds
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_WGT,
		ST_MAC,
		ST_DRAIN
	} state_t;

	typedef logic [W_W-1:0] weight_t;
	typedef logic [3:0][W_W-1:0] weight_vec_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} lane_ctrl_t;

endpackage

/* src/cbs_weight.sv */
module cbs_weight (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cbs_pkg::U_W-1:0]       t,
	input  logic [cbs_pkg::U_W-1:0]       r,
	output logic                          valid,
	output cbs_pkg::weight_vec_t          w
);
	import cbs_pkg::*;

	localparam logic [NUM_W-1:0] RND = NUM_W'(3) << 18;

	logic [4:0]             vld_q;
	logic [U_W-1:0]         t_s1, t_s2, r_s1;
	logic [2*U_W-1:0]       t2_s1, r2_s1, t2_s2;
	logic [NUM_W-1:0]       t3_s2, r3_s2;
	logic [3:0][NUM_W-1:0]  n_s3;
	logic [3:0][31:0]       h_s4;
	logic [NUM_W-1:0]       t3x3, t2s16, ts32, n1, n2;
	logic [3:0][63:0]       prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], start};
		end
	end

	// s3 numerators; n2 from the expanded basis, all mod 2^NUM_W
	always_comb begin
		t3x3  = (t3_s2 << 1) + t3_s2;
		t2s16 = NUM_W'(t2_s2) << 16;
		ts32  = NUM_W'(t_s2) << 32;
		n1    = t3x3 - (t2s16 << 2) - (t2s16 << 1) + (NUM_W'(1) << 50);
		n2    = (t2s16 << 1) + t2s16 + (ts32 << 1) + ts32 + (NUM_W'(1) << 48) - t3x3;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i] = 64'(h_s4[i]) * 64'(RECIP3);
		end
	end

	always_ff @(posedge clk) begin
		// s1: squares
		t_s1  <= t;
		r_s1  <= r;
		t2_s1 <= t * t;
		r2_s1 <= r * r;
		// s2: cubes
		t_s2  <= t_s1;
		t2_s2 <= t2_s1;
		t3_s2 <= NUM_W'(t2_s1) * NUM_W'(t_s1);
		r3_s2 <= NUM_W'(r2_s1) * NUM_W'(r_s1);
		// s3: numerators
		n_s3[0] <= r3_s2;
		n_s3[1] <= n1;
		n_s3[2] <= n2;
		n_s3[3] <= t3_s2;
		// s4: round and halve, /(6*2^18) = /2^19 then /3
		for (int i = 0; i < 4; i++) begin
			h_s4[i] <= 32'((n_s3[i] + RND) >> 19);
		end
		// s5: divide by three through the reciprocal
		for (int i = 0; i < 4; i++) begin
			w[i] <= W_W'(prod[i] >> 33);
		end
	end

	assign valid = vld_q[4];

endmodule

/* src/cbs_lane.sv */
module cbs_lane (
	input  logic                                 clk,
	input  cbs_pkg::lane_ctrl_t                  ctrl,
	input  cbs_pkg::weight_t                     weight,
	input  logic signed [cbs_pkg::COORD_W-1:0]   coord,
	output logic signed [cbs_pkg::COORD_W-1:0]   result
);
	import cbs_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << 29;

	logic signed [2*COORD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     rnd, sh;
	logic                        fits;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= $signed({1'b0, weight}) * coord;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + $signed({{(ACC_W-2*COORD_W){prod_s2[2*COORD_W-1]}}, prod_s2});
		end
	end

	// round to Q16.16 and saturate
	always_comb begin
		rnd  = acc_q + HALF;
		sh   = rnd >>> 30;
		fits = (&sh[ACC_W-1:COORD_W-1]) | ~(|sh[ACC_W-1:COORD_W-1]);
		if (fits) begin
			result = sh[COORD_W-1:0];
		end else if (sh[ACC_W-1]) begin
			result = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

endmodule

/* src/cubic_bspline_curve_sampler.sv */
// Uniform cubic B-spline curve sampler. Load items (tuser = 0) write one 3D
// control point into a 64-entry table; they give no output
// item. Sample items (tuser = 1) carry u in Q0.16 (65536 = 1.0, larger values
// act as 1.0) and give one item with x, y, z in signed Q16.16, rounded to
// nearest and saturated. Over M virtual points (point_count, clamped to 4..64,
// plus 4 when clamped_mode repeats the end points twice) the block picks
// segment floor(u*(M-3)), computes the four basis weights in Q0.30 in a
// five-stage pipeline, then reads the four control points one per cycle from
// the single-port table and feeds three coordinate lanes that multiply and
// accumulate side by side; the lane results merge into the output register.
// Between acceptance of a sample and the next acceptance the block runs a
// segment state, the weight stages, the table reads, the drain of the
// read/multiply/accumulate pipeline into the output register and an idle
// state that takes the next item. The output register holds a finished item
// while the block accepts the next one; a following sample waits in its
// last drain cycle until that register is free. The user must write the
// configuration (cfg_we/cfg_index/cfg_wdata) only while the block is idle;
// the block does not enforce it. Unloaded entries give undefined coordinates.
module cubic_bspline_curve_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [cbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbs_pkg::CNT_W-1:0]        cfg_wdata,
	// input items
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// point_index[5:0], point_x[37:6], point_y[69:38], point_z[101:70],
	// curve_param[118:102], zero[119]
	input  logic [119:0]                     s_axis_tdata,
	// opcode
	input  logic                             s_axis_tuser,
	// output items
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// curve_x[31:0], curve_y[63:32], curve_z[95:64]
	output logic [95:0]                      m_axis_tdata
);
	import cbs_pkg::*;

	// input field positions
	localparam int X_LSB = IDX_W;
	localparam int Y_LSB = X_LSB + COORD_W;
	localparam int Z_LSB = Y_LSB + COORD_W;
	localparam int U_LSB = Z_LSB + COORD_W;

	// ---- configuration registers
	logic             clamped_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamped_q <= 1'b0;
			count_q   <= MIN_CNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLAMPED: clamped_q <= cfg_wdata[0];
				CFG_COUNT:   count_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// points in use and segment count; user keeps them stable while a sample runs
	logic [CNT_W-1:0] p_eff;
	logic [SEG_W-1:0] n_seg;

	always_comb begin
		if (count_q < MIN_CNT) begin
			p_eff = MIN_CNT;
		end else if (count_q > MAX_CNT) begin
			p_eff = MAX_CNT;
		end else begin
			p_eff = count_q;
		end
		n_seg = SEG_W'(p_eff) + (clamped_q ? SEG_W'(4) : SEG_W'(0)) - SEG_W'(3);
	end

	// ---- input unpack
	logic [IDX_W-1:0] in_index;
	point_t           in_point;
	logic [U_W-1:0]   in_u, u_sat;
	logic             in_fire, load_fire, sample_fire;

	assign in_index   = s_axis_tdata[IDX_W-1:0];
	assign in_point.x = s_axis_tdata[X_LSB +: COORD_W];
	assign in_point.y = s_axis_tdata[Y_LSB +: COORD_W];
	assign in_point.z = s_axis_tdata[Z_LSB +: COORD_W];
	assign in_u       = s_axis_tdata[U_LSB +: U_W];
	assign u_sat      = (in_u > ONE_Q16) ? ONE_Q16 : in_u;

	assign in_fire     = s_axis_tvalid & s_axis_tready;
	assign load_fire   = in_fire & (s_axis_tuser == OP_LOAD);
	assign sample_fire = in_fire & (s_axis_tuser == OP_SAMPLE);

	// ---- control state
	state_t   state_q, state_d;
	logic [1:0] k_q, k_d;
	logic     rdv_s1, mulv_s2;
	logic [1:0] rdk_s1;
	logic     out_load;
	logic     m_valid_q;

	// u*N taken at acceptance; full marks u = 1.0 (last segment, t = 1)
	logic [23:0]      un_q;
	logic             full_q;
	logic [SEG_W-1:0] s_q;

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			un_q   <= 24'(u_sat) * 24'(n_seg);
			full_q <= (u_sat == ONE_Q16);
		end
	end

	// segment and fraction
	logic [SEG_W-1:0] s_d;
	logic [U_W-1:0]   t_d, r_d;

	always_comb begin
		s_d = full_q ? (n_seg - SEG_W'(1)) : un_q[16 +: SEG_W];
		t_d = full_q ? ONE_Q16 : {1'b0, un_q[15:0]};
		r_d = ONE_Q16 - t_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEG) begin
			s_q <= s_d;
		end
	end

	// ---- weights
	logic        w_valid;
	weight_vec_t w_vec;

	cbs_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SEG),
		.t      (t_d),
		.r      (r_d),
		.valid  (w_valid),
		.w      (w_vec)
	);

	// ---- virtual point to table entry
	logic [SEG_W-1:0] j_virt, j_off, e_full;
	logic [IDX_W-1:0] entry;

	always_comb begin
		j_virt = s_q + SEG_W'(k_q);
		j_off  = j_virt - SEG_W'(2);
		if (clamped_q) begin
			if (j_virt < SEG_W'(2)) begin
				e_full = '0;
			end else if (j_off >= SEG_W'(p_eff)) begin
				e_full = SEG_W'(p_eff) - SEG_W'(1);
			end else begin
				e_full = j_off;
			end
		end else begin
			e_full = (j_virt < SEG_W'(p_eff)) ? j_virt : SEG_W'(p_eff) - SEG_W'(1);
		end
		entry = e_full[IDX_W-1:0];
	end

	// ---- control point table, single port; point_index always fits the table
	point_t           mem [MAX_POINTS];
	point_t           rd_q;
	logic [IDX_W-1:0] mem_addr;

	assign mem_addr = (state_q == ST_MAC) ? entry : in_index;

	always_ff @(posedge clk) begin
		if (load_fire) begin
			mem[mem_addr] <= in_point;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[mem_addr];
	end

	// ---- read / multiply / accumulate tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1  <= 1'b0;
			rdk_s1  <= '0;
			mulv_s2 <= 1'b0;
		end else begin
			rdv_s1  <= (state_q == ST_MAC);
			rdk_s1  <= k_q;
			mulv_s2 <= rdv_s1;
		end
	end

	// ---- coordinate lanes
	lane_ctrl_t        lane_ctrl;
	logic signed [COORD_W-1:0] res_x, res_y, res_z;

	assign lane_ctrl.clear  = (state_q == ST_SEG);
	assign lane_ctrl.mul_en = rdv_s1;
	assign lane_ctrl.acc_en = mulv_s2;

	cbs_lane u_lane_x (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.weight (w_vec[rdk_s1]),
		.coord  (rd_q.x),
		.result (res_x)
	);

	cbs_lane u_lane_y (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.weight (w_vec[rdk_s1]),
		.coord  (rd_q.y),
		.result (res_y)
	);

	cbs_lane u_lane_z (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.weight (w_vec[rdk_s1]),
		.coord  (rd_q.z),
		.result (res_z)
	);

	// ---- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_fire) begin
					state_d = ST_SEG;
				end
			end
			ST_SEG: begin
				state_d = ST_WGT;
			end
			ST_WGT: begin
				k_d = '0;
				if (w_valid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				k_d = k_q + 2'd1;
				if (k_q == LAST_TAP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last product accumulated and output register free
				if (!rdv_s1 && !mulv_s2 && (!m_valid_q || m_axis_tready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// ---- merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {res_z, res_y, res_x};
		end
	end

	assign m_axis_tvalid = m_valid_q;

	// ---- checks
	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		w_valid |-> ((33'(w_vec[0]) + 33'(w_vec[1]) + 33'(w_vec[2]) + 33'(w_vec[3])
			<= 33'd1073741826) &&
			(33'(w_vec[0]) + 33'(w_vec[1]) + 33'(w_vec[2]) + 33'(w_vec[3])
			>= 33'd1073741822)))
		else $error("basis weights do not sum to one");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (CNT_W'(entry) < p_eff))
		else $error("table read beyond points in use");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!rdv_s1 && !mulv_s2))
		else $error("input taken while lanes busy");

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DRAIN))
		else $error("output item not from drain");

endmodule
